// ===== rtl/core/rsa_pkg.sv =====
// Package: types, widths and codes of the running statistics accumulator.
`default_nettype none
package rsa_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned COUNT_BITS  = 32;
  localparam int unsigned FRAC_BITS   = 8;

  localparam int unsigned SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
  localparam int unsigned SQ_BITS     = 2 * SAMPLE_BITS;
  localparam int unsigned SUMSQ_BITS  = 2 * (SAMPLE_BITS - 1) + COUNT_BITS + 1;
  localparam int unsigned MEAN_BITS   = SAMPLE_BITS + FRAC_BITS;
  localparam int unsigned VAR_BITS    = 2 * (SAMPLE_BITS - 1) + FRAC_BITS;
  localparam int unsigned MSQ_BITS    = 2 * MEAN_BITS;

  // Divider: dividend is the accumulator scaled by 2^FRAC_BITS
  localparam int unsigned MEAN_DIV_BITS = SUM_BITS + FRAC_BITS;
  localparam int unsigned DIV_BITS      = SUMSQ_BITS + FRAC_BITS;
  localparam int unsigned QUO_BITS      = VAR_BITS + 1;
  localparam int unsigned STEP_BITS     = $clog2(DIV_BITS + 1);

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } rsa_op_e;

  typedef struct packed {
    rsa_op_e                        operation;
    logic signed [SAMPLE_BITS-1:0]  sample;
  } rsa_in_t;

  typedef struct packed {
    logic [31:0]        sample_count;
    logic               have_samples;
    logic signed [15:0] minimum;
    logic signed [15:0] maximum;
    logic signed [23:0] mean_q8;
    logic [37:0]        variance_q8;
    logic               overflowed;
  } rsa_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MEAN_START,
    ST_MEAN_WAIT,
    ST_VAR_START,
    ST_VAR_WAIT,
    ST_FINISH,
    ST_EMIT
  } rsa_state_e;

  typedef struct packed {
    logic capture;
    logic update;
    logic div_start;
    logic div_mean;
    logic take_mean;
    logic take_var;
    logic finish;
    logic emit;
  } rsa_cmd_t;

  typedef struct packed {
    logic empty;
    logic div_done;
    logic out_busy;
  } rsa_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/rsa_div.sv =====
// Bit-serial restoring divider producing floor(dividend / divisor).
`default_nettype none
module rsa_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [rsa_pkg::DIV_BITS-1:0]    dividend_i,
  input  wire logic [rsa_pkg::STEP_BITS-1:0]   steps_i,
  input  wire logic [rsa_pkg::COUNT_BITS-1:0]  divisor_i,
  output logic                                 done_o,
  output logic [rsa_pkg::QUO_BITS-1:0]         quotient_o
);
  import rsa_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_BITS-1:0]  step_q, step_d;
  logic [DIV_BITS-1:0]   dvd_q, dvd_d;
  logic [COUNT_BITS-1:0] dvs_q, dvs_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [QUO_BITS-1:0]   quo_q, quo_d;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  ge;

  assign trial = {rem_q, dvd_q[DIV_BITS-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = steps_i;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      dvd_d  = {dvd_q[DIV_BITS-2:0], 1'b0};
      rem_d  = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      quo_d  = {quo_q[QUO_BITS-2:0], ge};
      step_d = step_q - STEP_BITS'(1);
      if (step_q == STEP_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ===== rtl/core/rsa_datapath.sv =====
// Datapath: accumulators, shared divider, variance arithmetic and result register.
`default_nettype none
module rsa_datapath (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire rsa_pkg::rsa_in_t      in_data_i,
  input  wire rsa_pkg::rsa_cmd_t     cmd_i,
  output rsa_pkg::rsa_status_t       status_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output rsa_pkg::rsa_out_t          out_data_o
);
  import rsa_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [VAR_BITS-1:0]           VAR_MAX    = '1;
  localparam int unsigned                   CMP_BITS   = MSQ_BITS + 1;

  // captured item
  rsa_op_e                       op_q;
  logic signed [SAMPLE_BITS-1:0] smp_q;
  logic [SQ_BITS-1:0]            sq_q;
  logic signed [SQ_BITS-1:0]     sq_prod;

  // statistics state
  logic [COUNT_BITS-1:0]         count_q, count_d;
  logic signed [SUM_BITS-1:0]    sum_q, sum_d;
  logic [SUMSQ_BITS-1:0]         sumsq_q, sumsq_d;
  logic signed [SAMPLE_BITS-1:0] min_q, min_d;
  logic signed [SAMPLE_BITS-1:0] max_q, max_d;
  logic                          ovf_q, ovf_d;

  // derived values
  logic                          sum_neg;
  logic [SUM_BITS-1:0]           sum_mag;
  logic [DIV_BITS-1:0]           dividend;
  logic [STEP_BITS-1:0]          steps;
  logic                          div_done;
  logic [QUO_BITS-1:0]           quotient;
  logic [MEAN_BITS-1:0]          mmag_q;
  logic [MSQ_BITS-1:0]           msq_q;
  logic [QUO_BITS-1:0]           a_q;
  logic [VAR_BITS-1:0]           var_q, var_d;
  logic [CMP_BITS-1:0]           a_ext, b_ext, var_diff;
  logic signed [MEAN_BITS-1:0]   mean_val;

  // output register
  logic                          out_valid_q, out_valid_d;
  rsa_out_t                      out_q, out_d;

  assign sq_prod = in_data_i.sample * in_data_i.sample;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= in_data_i.operation;
      smp_q <= in_data_i.sample;
      sq_q  <= SQ_BITS'(unsigned'(sq_prod));
    end
  end

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    sumsq_d = sumsq_q;
    min_d   = min_q;
    max_d   = max_q;
    ovf_d   = ovf_q;
    if (cmd_i.update) begin
      unique case (op_q)
        OP_CLEAR: begin
          count_d = '0;
          sum_d   = '0;
          sumsq_d = '0;
          min_d   = SAMPLE_MAX;
          max_d   = SAMPLE_MIN;
          ovf_d   = 1'b0;
        end
        OP_ADD: begin
          if (&count_q) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + COUNT_BITS'(1);
            sum_d   = sum_q + SUM_BITS'(smp_q);
            sumsq_d = sumsq_q + SUMSQ_BITS'(sq_q);
            if (smp_q < min_q) begin
              min_d = smp_q;
            end
            if (smp_q > max_q) begin
              max_d = smp_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
      min_q   <= SAMPLE_MAX;
      max_q   <= SAMPLE_MIN;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      sumsq_q <= sumsq_d;
      min_q   <= min_d;
      max_q   <= max_d;
      ovf_q   <= ovf_d;
    end
  end

  // divider operands, dividend left-aligned so the step count sets its length
  assign sum_neg = sum_q[SUM_BITS-1];
  assign sum_mag = sum_neg ? SUM_BITS'(-sum_q) : SUM_BITS'(sum_q);

  always_comb begin
    if (cmd_i.div_mean) begin
      dividend = DIV_BITS'(sum_mag) << (FRAC_BITS + DIV_BITS - MEAN_DIV_BITS);
      steps    = STEP_BITS'(MEAN_DIV_BITS);
    end else begin
      dividend = DIV_BITS'(sumsq_q) << FRAC_BITS;
      steps    = STEP_BITS'(DIV_BITS);
    end
  end

  rsa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .steps_i    (steps),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // variance: a - (mean^2 >> F), clamped both ways
  assign a_ext = CMP_BITS'(a_q);
  assign b_ext = CMP_BITS'(msq_q >> FRAC_BITS);
  assign var_diff = a_ext - b_ext;

  always_comb begin
    var_d = var_q;
    if (cmd_i.finish) begin
      if (a_ext <= b_ext) begin
        var_d = '0;
      end else if (var_diff > CMP_BITS'(VAR_MAX)) begin
        var_d = VAR_MAX;
      end else begin
        var_d = var_diff[VAR_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_mean) begin
      mmag_q <= quotient[MEAN_BITS-1:0];
    end
    if (cmd_i.take_var) begin
      a_q <= quotient;
    end
    msq_q <= mmag_q * mmag_q;
    var_q <= var_d;
  end

  assign mean_val = sum_neg ? MEAN_BITS'(-signed'(mmag_q)) : signed'(mmag_q);

  always_comb begin
    out_d = out_q;
    if (cmd_i.emit) begin
      out_d.sample_count = 32'(count_q);
      out_d.have_samples = !status_o.empty;
      out_d.overflowed   = ovf_q;
      if (status_o.empty) begin
        out_d.minimum     = '0;
        out_d.maximum     = '0;
        out_d.mean_q8     = '0;
        out_d.variance_q8 = '0;
      end else begin
        out_d.minimum     = 16'(min_q);
        out_d.maximum     = 16'(max_q);
        out_d.mean_q8     = 24'(mean_val);
        out_d.variance_q8 = 38'(var_q);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign status_o.empty    = (count_q == '0);
  assign status_o.div_done = div_done;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== rtl/core/rsa_ctrl.sv =====
// Controller: sequences update, the two divisions, variance and result transfer.
`default_nettype none
module rsa_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire rsa_pkg::rsa_status_t  status_i,
  output rsa_pkg::rsa_cmd_t          cmd_o
);
  import rsa_pkg::*;

  rsa_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:       if (in_valid_i) state_d = ST_UPDATE;
      ST_UPDATE:     state_d = ST_MEAN_START;
      ST_MEAN_START: state_d = status_i.empty ? ST_EMIT : ST_MEAN_WAIT;
      ST_MEAN_WAIT:  if (status_i.div_done) state_d = ST_VAR_START;
      ST_VAR_START:  state_d = ST_VAR_WAIT;
      ST_VAR_WAIT:   if (status_i.div_done) state_d = ST_FINISH;
      ST_FINISH:     state_d = ST_EMIT;
      ST_EMIT:       if (!status_i.out_busy) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_UPDATE:     cmd_o.update = 1'b1;
      ST_MEAN_START: begin
        cmd_o.div_mean  = 1'b1;
        cmd_o.div_start = !status_i.empty;
      end
      ST_MEAN_WAIT:  cmd_o.take_mean = status_i.div_done;
      ST_VAR_START:  cmd_o.div_start = 1'b1;
      ST_VAR_WAIT:   cmd_o.take_var = status_i.div_done;
      ST_FINISH:     cmd_o.finish = 1'b1;
      ST_EMIT:       cmd_o.emit = !status_i.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/running_statistics_accumulator_core.sv =====
// Running statistics accumulator: count, min, max, mean and variance of samples.
//
// Input channel (in_valid_i/in_ready_o/in_data_i): one transfer is either
// an added sample or a clear command. Output channel (out_valid_o/
// out_ready_i/out_data_o): exactly one result per input transfer, in order.
// Mean and variance come from two passes through one bit-serial divider,
// one quotient bit per cycle: 56 steps for the mean, 71 for the variance.
// An item is finished and its result emitted before the next transfer is
// taken. When no samples are held (after a clear) the divider is skipped.
// The result sits in an output register; a new item is taken while it
// waits. If the receiver stalls, the next result is held back until the
// register frees, and input is not taken meanwhile.
// Reset empties the statistics: count zero, minimum at the most positive
// and maximum at the most negative sample, overflow flag low.
`default_nettype none
module running_statistics_accumulator_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rsa_pkg::rsa_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rsa_pkg::rsa_out_t      out_data_o
);
  import rsa_pkg::*;

  rsa_cmd_t    cmd;
  rsa_status_t status;

  rsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rsa_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ===== test/tb_running_statistics_accumulator_core.sv =====
// Testbench for running_statistics_accumulator_core: bursty random traffic, scored predictor.
module tb_running_statistics_accumulator_core;
  import rsa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned HOLDOFF_AT = 400;
  localparam int unsigned HOLDOFF_CYCLES = 3000;
  localparam int unsigned TAIL_CYCLES = 300;
  localparam logic [63:0] VAR_MAX = (64'd1 << VAR_BITS) - 64'd1;

  typedef struct {
    rsa_in_t data;
    bit      drain_first;
  } stim_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  rsa_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rsa_out_t out_data;

  stim_t    stim_q[$];
  rsa_out_t results_due[$];

  // predictor state
  logic [31:0]        n_samples;
  longint signed      run_sum;
  logic [63:0]        run_sum_sq;
  logic signed [15:0] run_min;
  logic signed [15:0] run_max;
  bit                 count_sat;

  int unsigned cycle_count = 0;
  int unsigned items_taken = 0;
  int unsigned fault_count = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned phase_left = 0;
  int unsigned ready_mode = 0;

  running_statistics_accumulator_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  function automatic void clear_stats();
    n_samples  = '0;
    run_sum    = 0;
    run_sum_sq = '0;
    run_min    = 16'sh7fff;
    run_max    = -16'sh8000;
    count_sat  = 1'b0;
  endfunction

  // floor(a * 2^FRAC_BITS / d), d > 0
  function automatic logic [63:0] scaled_quotient(logic [63:0] a, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = a / d;
    r = a % d;
    return (q << FRAC_BITS) + ((r << FRAC_BITS) / d);
  endfunction

  function automatic rsa_out_t predict_stats(rsa_in_t item);
    longint signed v;
    logic [63:0]   mag;
    logic [63:0]   mean_mag;
    logic [63:0]   sq_term;
    logic [63:0]   mean_sq;
    logic [63:0]   var_val;
    bit            neg;
    rsa_out_t      r;
    v = longint'(item.sample);
    if (item.operation == OP_CLEAR) begin
      clear_stats();
    end else if (n_samples == '1) begin
      count_sat = 1'b1;
    end else begin
      if (v < run_min) run_min = v[15:0];
      if (v > run_max) run_max = v[15:0];
      n_samples  = n_samples + 1;
      run_sum    = run_sum + v;
      run_sum_sq = run_sum_sq + 64'(v * v);
    end
    r = '0;
    r.sample_count = n_samples;
    r.have_samples = (n_samples != 0);
    r.overflowed   = count_sat;
    if (n_samples != 0) begin
      neg      = (run_sum < 0);
      mag      = neg ? 64'(-run_sum) : 64'(run_sum);
      mean_mag = scaled_quotient(mag, 64'(n_samples));
      sq_term  = scaled_quotient(run_sum_sq, 64'(n_samples));
      mean_sq  = (mean_mag * mean_mag) >> FRAC_BITS;
      var_val  = (sq_term > mean_sq) ? sq_term - mean_sq : 64'd0;
      if (var_val > VAR_MAX) var_val = VAR_MAX;
      r.minimum     = run_min;
      r.maximum     = run_max;
      r.mean_q8     = neg ? 24'(-mean_mag) : 24'(mean_mag);
      r.variance_q8 = var_val[37:0];
    end
    return r;
  endfunction

  task automatic queue_add(logic signed [15:0] v, bit drain = 1'b0);
    stim_t s;
    s.data.operation = OP_ADD;
    s.data.sample    = v;
    s.drain_first    = drain;
    stim_q = {stim_q, s};
  endtask

  task automatic queue_clear(logic [15:0] junk = '0);
    stim_t s;
    s.data.operation = OP_CLEAR;
    s.data.sample    = junk;
    s.drain_first    = 1'b0;
    stim_q = {stim_q, s};
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      fault_count++;
      if (fault_count <= 10)
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, exp_v, act_v);
    end
  endtask

  // sender: bursts of transfers separated by random gaps
  always @(posedge clk_i) begin : drive_proc
    stim_t   nxt;
    logic    v;
    rsa_in_t d;
    v = in_valid;
    d = in_data;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        results_due = {results_due, predict_stats(in_data)};
        items_taken++;
        v = 1'b0;
      end
      if (!v) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (stim_q.size() != 0 &&
                     !(stim_q[0].drain_first && results_due.size() != 0)) begin
          nxt = stim_q.pop_front();
          v = 1'b1;
          d = nxt.data;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
          end else begin
            burst_left--;
          end
        end
      end
    end
    in_valid <= v;
    in_data  <= d;
  end

  // receiver: stall pattern changes phase now and then; one long hold-off
  always @(posedge clk_i) begin : ready_proc
    logic r;
    r = 1'b0;
    if (hold_left != 0) begin
      hold_left--;
    end else if (!hold_done && items_taken >= HOLDOFF_AT) begin
      hold_done = 1'b1;
      hold_left = HOLDOFF_CYCLES;
    end else begin
      if (phase_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        phase_left = $urandom_range(200, 3000);
      end else begin
        phase_left--;
      end
      case (ready_mode)
        0: r = 1'b1;
        1: r = ($urandom_range(0, 99) < 75);
        2: r = ($urandom_range(0, 99) < 25);
        default: r = (cycle_count % 7) > 2;
      endcase
    end
    out_ready <= r;
  end

  always @(posedge clk_i) begin : result_proc
    rsa_out_t exp_r;
    if (rst_ni && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: result with none expected: %h", $realtime, out_data);
      end else begin
        exp_r = results_due.pop_front();
        check_field("sample_count", 64'(exp_r.sample_count), 64'(out_data.sample_count));
        check_field("have_samples", 64'(exp_r.have_samples), 64'(out_data.have_samples));
        check_field("minimum", 64'(exp_r.minimum), 64'(out_data.minimum));
        check_field("maximum", 64'(exp_r.maximum), 64'(out_data.maximum));
        check_field("mean_q8", 64'(exp_r.mean_q8), 64'(out_data.mean_q8));
        check_field("variance_q8", 64'(exp_r.variance_q8), 64'(out_data.variance_q8));
        check_field("overflowed", 64'(exp_r.overflowed), 64'(out_data.overflowed));
      end
    end
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("tb_running_statistics_accumulator_core: done, errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned n;
    int unsigned drain_at;
    logic [15:0] s;
    clear_stats();

    // directed: empty clear, extremes, truncation toward zero, clear on empty
    queue_clear();
    queue_add(16'sh7fff);
    queue_add(-16'sh8000);
    queue_add(16'sh0000);
    queue_add(-16'sh0001);
    queue_add(16'sh0001);
    queue_clear(16'hffff);
    queue_add(-16'sh8000);
    queue_add(-16'sh8000);
    queue_clear(16'h5a5a);
    queue_add(16'sh7fff);
    queue_add(16'sh7fff);
    queue_add(16'sh7fff);
    queue_clear();
    queue_add(-16'sh0001);
    queue_add(16'sh0000);
    queue_add(16'sh0000);
    queue_clear();
    queue_clear(16'h8001);
    queue_add(-16'sh8000);
    queue_add(16'sh7fff);
    queue_add(-16'sh8000);
    queue_add(16'sh7fff);
    queue_clear(16'h7ffe);

    drain_at = $urandom_range(600, 1200);
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 3) begin
        queue_clear(16'($urandom_range(0, 65535)));
      end else begin
        case ($urandom_range(0, 9))
          0, 1: begin
            case ($urandom_range(0, 5))
              0: s = 16'h8000;
              1: s = 16'h7fff;
              2: s = 16'h8001;
              3: s = 16'h7ffe;
              4: s = 16'h0000;
              default: s = 16'hffff;
            endcase
          end
          2, 3, 4, 5: s = 16'($urandom_range(0, 65535));
          default: s = 16'($urandom_range(0, 255)) - 16'd128;
        endcase
        queue_add(s, (n == 0) || (n == drain_at));
      end
      n++;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (stim_q.size() != 0 || in_valid || results_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    fault_count += results_due.size();
    if (fault_count == 0) begin
      $display("tb_running_statistics_accumulator_core: done, clean");
    end else begin
      $display("tb_running_statistics_accumulator_core: done, errors");
    end
    $finish;
  end

endmodule
